// ===== sv/lbpg_pkg.sv =====
// shared types, codes and helpers for the led blink pattern generator
package lbpg_pkg;

   localparam int UnitW  = 8;
   localparam int CountW = 16;

   localparam logic [UnitW-1:0] UNIT_TICKS_RESET = 8'd10;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_ON    = 3'd1,
      PH_OFF   = 3'd2,
      PH_PAUSE = 3'd3,
      PH_END   = 3'd4
   } phase_type;

   localparam logic [2:0] MODE_ON        = 3'd0;
   localparam logic [2:0] MODE_OFF       = 3'd1;
   localparam logic [2:0] MODE_CFG_WAIT  = 3'd2;
   localparam logic [2:0] MODE_POS_WAIT  = 3'd3;
   localparam logic [2:0] MODE_READY     = 3'd4;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_NOTIFY = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [2:0] mode;
   } item_type;

   typedef struct packed {
      logic [1:0] on_units;
      logic [1:0] off_units;
      logic [1:0] flash_count;
      logic [2:0] pause_units;
   } pattern_type;

   function automatic pattern_type pattern_of(input logic [2:0] mode);
      pattern_type p;
      p = '0;
      unique case (mode)
         MODE_ON:       p = '{2'd1, 2'd0, 2'd0, 3'd0};
         MODE_OFF:      p = '{2'd0, 2'd1, 2'd0, 3'd0};
         MODE_CFG_WAIT: p = '{2'd3, 2'd3, 2'd3, 3'd6};
         MODE_POS_WAIT: p = '{2'd3, 2'd3, 2'd2, 3'd6};
         MODE_READY:    p = '{2'd3, 2'd3, 2'd1, 3'd0};
         default:       p = '0;
      endcase
      return p;
   endfunction

   function automatic logic mode_known(input logic [2:0] mode);
      return (mode == MODE_ON) || (mode == MODE_OFF) || (mode == MODE_CFG_WAIT) ||
             (mode == MODE_POS_WAIT) || (mode == MODE_READY);
   endfunction

   // units times ticks per unit, at most 7 * 255
   function automatic logic [CountW-1:0] load_count(input logic [2:0] units,
                                                     input logic [UnitW-1:0] unit_ticks);
      logic [10:0] prod;
      prod = 11'(units) * 11'(unit_ticks);
      return CountW'(prod);
   endfunction

endpackage

// ===== sv/led_blink_pattern_generator.sv =====
// led blink pattern generator top level: input word register, sequencer, result register
//
// channel  dir  handshake                 payload
// req      in   req_tvalid / req_tready   tuser = cmd, tdata = mode
// rsp      out  rsp_tvalid / rsp_tready   tdata = led_level
// csr      in   csr_we                    csr_wdata = unit_ticks
//
// one word per cycle sustained while rsp is not stalled; each word is held in the input
// register and then in the result register before it appears on rsp.
// the sequencer state advances only when the input register hands its word to
// the result register, so a stalled rsp holds both stages and then req_tready.
// reset clears the valid flags and the sequencer state and loads unit_ticks with 10.
module led_blink_pattern_generator
   import lbpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] mode, [7:3] zero
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] led_level, [7:1] zero
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic [UnitW-1:0] unit_ticks_ff;
   logic             in_valid_ff;
   item_type         in_item_ff;
   logic             out_valid_ff;
   logic             led_ff;
   logic             advance;
   logic             lamp_next;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, led_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
      end else if (csr_we) begin
         unit_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= '{cmd: req_tuser, mode: req_tdata[2:0]};
      end
   end

   lbpg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .unit_ticks (unit_ticks_ff),
      .lamp_next  (lamp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_ff <= lamp_next;
      end
   end

endmodule

// ===== sv/lbpg_seq.sv =====
// pattern sequencer: pattern registers, phase, tick counter and led level
module lbpg_seq
   import lbpg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  item_type         item,
   input  logic [UnitW-1:0] unit_ticks,
   output logic             lamp_next
);

   phase_type         phase_ff, phase_in;
   pattern_type       pat_ff, pat_in;
   logic [1:0]        flashes_ff, flashes_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              lamp_ff, lamp_in;

   logic [CountW-1:0] count_dec;
   logic              count_zero;
   logic [1:0]        flashes_dec;
   logic              is_tick;
   logic              is_load;

   assign count_dec   = count_ff - CountW'(1);
   assign count_zero  = (count_dec == '0);
   assign flashes_dec = flashes_ff - 2'd1;
   assign is_tick     = step && (item.cmd == CMD_TICK);
   assign is_load     = step && (item.cmd == CMD_NOTIFY) && mode_known(item.mode);
   assign lamp_next   = lamp_in;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_load) begin
         phase_in = PH_START;
      end else if (is_tick) begin
         unique case (phase_ff)
            PH_START: phase_in = (pat_ff.on_units != '0) ? PH_ON : PH_END;
            PH_ON: begin
               if (count_zero) begin
                  phase_in = (pat_ff.off_units != '0) ? PH_OFF : PH_END;
               end
            end
            PH_OFF: begin
               if (count_zero) begin
                  priority if (flashes_dec != '0) phase_in = PH_ON;
                  else if (pat_ff.pause_units != '0) phase_in = PH_PAUSE;
                  else phase_in = PH_START;
               end
            end
            PH_PAUSE: begin
               if (count_zero) begin
                  phase_in = PH_START;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // counter, flash count, lamp and pattern
   always_comb begin
      pat_in     = pat_ff;
      flashes_in = flashes_ff;
      count_in   = count_ff;
      lamp_in    = lamp_ff;
      if (is_load) begin
         pat_in = pattern_of(item.mode);
      end else if (is_tick) begin
         unique case (phase_ff)
            PH_START: begin
               if (pat_ff.on_units != '0) begin
                  count_in   = load_count({1'b0, pat_ff.on_units}, unit_ticks);
                  flashes_in = pat_ff.flash_count;
                  lamp_in    = 1'b1;
               end else if (pat_ff.off_units != '0) begin
                  lamp_in = 1'b0;
               end
            end
            PH_ON: begin
               count_in = count_dec;
               if (count_zero && (pat_ff.off_units != '0)) begin
                  count_in = load_count({1'b0, pat_ff.off_units}, unit_ticks);
                  lamp_in  = 1'b0;
               end
            end
            PH_OFF: begin
               count_in = count_dec;
               if (count_zero) begin
                  flashes_in = flashes_dec;
                  priority if (flashes_dec != '0) begin
                     count_in = load_count({1'b0, pat_ff.on_units}, unit_ticks);
                     lamp_in  = 1'b1;
                  end else if (pat_ff.pause_units != '0) begin
                     count_in = load_count(pat_ff.pause_units, unit_ticks);
                  end
               end
            end
            PH_PAUSE: count_in = count_dec;
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         pat_ff     <= '0;
         flashes_ff <= '0;
         count_ff   <= '0;
         lamp_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pat_ff     <= pat_in;
         flashes_ff <= flashes_in;
         count_ff   <= count_in;
         lamp_ff    <= lamp_in;
      end
   end

endmodule
